>>> design/dsts_pkg.sv
package dsts_pkg;

  typedef logic        [31:0] err_t;
  typedef logic signed [31:0] feat_t;
  typedef logic        [23:0] weight_t;
  typedef logic        [9:0]  col_t;

  localparam err_t ErrMax = '1;

  typedef enum logic {
    CfgTotalPos = 1'b0,
    CfgTotalNeg = 1'b1
  } cfg_idx_e;

  // one sample as taken from the input channel
  typedef struct packed {
    feat_t   feature_value;
    logic    label_positive;
    weight_t sample_weight;
    col_t    column_index;
    logic    last_in_column;
    logic    last_column;
  } sample_t;

  // column state at the closing sample, before the final candidate check
  typedef struct packed {
    err_t  min_pos;
    err_t  min_neg;
    feat_t thr_pos;
    feat_t thr_neg;
    err_t  run_pos;
    err_t  run_neg;
    feat_t value;
    col_t  col;
    logic  last_col;
  } close_t;

  // best stump of one column
  typedef struct packed {
    err_t  err;
    logic  pol;
    feat_t thr;
    col_t  col;
    logic  last_col;
  } stump_t;

  // one result item
  typedef struct packed {
    err_t  col_error;
    logic  col_polarity;
    feat_t col_threshold;
    col_t  col_number;
    err_t  best_error;
    logic  best_polarity;
    feat_t best_threshold;
    col_t  best_column;
    logic  round_done;
  } result_t;

  function automatic err_t sat_add(err_t a, weight_t w);
    logic [32:0] s;
    s = {1'b0, a} + {9'b0, w};
    return s[32] ? ErrMax : s[31:0];
  endfunction

  function automatic err_t sat_sub(err_t a, weight_t w);
    return (a < {8'b0, w}) ? '0 : (a - {8'b0, w});
  endfunction

endpackage

>>> design/dsts_if.sv
interface dsts_sample_if;
  import dsts_pkg::*;

  logic    valid;
  logic    ready;
  feat_t   feature_value;
  logic    label_positive;
  weight_t sample_weight;
  col_t    column_index;
  logic    last_in_column;
  logic    last_column;

  modport source (
    output valid, feature_value, label_positive, sample_weight, column_index,
           last_in_column, last_column,
    input  ready
  );

  modport sink (
    input  valid, feature_value, label_positive, sample_weight, column_index,
           last_in_column, last_column,
    output ready
  );
endinterface

interface dsts_result_if;
  import dsts_pkg::*;

  logic  valid;
  logic  ready;
  err_t  col_error;
  logic  col_polarity;
  feat_t col_threshold;
  col_t  col_number;
  err_t  best_error;
  logic  best_polarity;
  feat_t best_threshold;
  col_t  best_column;
  logic  round_done;

  modport source (
    output valid, col_error, col_polarity, col_threshold, col_number,
           best_error, best_polarity, best_threshold, best_column, round_done,
    input  ready
  );

  modport sink (
    input  valid, col_error, col_polarity, col_threshold, col_number,
           best_error, best_polarity, best_threshold, best_column, round_done,
    output ready
  );
endinterface

>>> design/dsts_scan.sv
module dsts_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dsts_pkg::cfg_idx_e cfg_idx_i,
  input  dsts_pkg::err_t     cfg_data_i,
  dsts_sample_if.sink        sample,
  output logic               close_valid_o,
  output dsts_pkg::close_t   close_o,
  input  logic               close_ready_i
);
  import dsts_pkg::*;

  err_t    total_pos_q, total_neg_q;
  logic    in_valid_q;
  sample_t in_q;
  logic    close_valid_q;
  close_t  close_q;
  logic    open_q, pend_q;
  err_t    run_pos_q, run_neg_q, min_pos_q, min_neg_q;
  feat_t   thr_pos_q, thr_neg_q, prev_q;

  err_t    run_pos_d, run_neg_d, min_pos_d, min_neg_d;
  feat_t   thr_pos_d, thr_neg_d;
  logic    close_free, in_fire;

  assign close_free   = !close_valid_q || close_ready_i;
  assign in_fire      = in_valid_q && (!in_q.last_in_column || close_free);
  assign sample.ready = !in_valid_q || in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_pos_q <= '0;
      total_neg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTotalPos: total_pos_q <= cfg_data_i;
        CfgTotalNeg: total_neg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // candidate check on the older sample and error update run side by side
  always_comb begin
    err_t  base_rp, base_rn, base_mp, base_mn;
    feat_t base_tp, base_tn;
    logic  start, eval;
    start   = !open_q;
    base_rp = start ? total_pos_q : run_pos_q;
    base_rn = start ? total_neg_q : run_neg_q;
    base_mp = start ? ErrMax : min_pos_q;
    base_mn = start ? ErrMax : min_neg_q;
    base_tp = start ? '0 : thr_pos_q;
    base_tn = start ? '0 : thr_neg_q;
    eval    = !start && pend_q && (in_q.feature_value != prev_q);

    min_pos_d = base_mp;
    thr_pos_d = base_tp;
    if (eval && (base_rp < base_mp)) begin
      min_pos_d = base_rp;
      thr_pos_d = prev_q;
    end
    min_neg_d = base_mn;
    thr_neg_d = base_tn;
    if (eval && (base_rn < base_mn)) begin
      min_neg_d = base_rn;
      thr_neg_d = prev_q;
    end

    if (in_q.label_positive) begin
      run_pos_d = sat_sub(base_rp, in_q.sample_weight);
      run_neg_d = sat_add(base_rn, in_q.sample_weight);
    end else begin
      run_pos_d = sat_add(base_rp, in_q.sample_weight);
      run_neg_d = sat_sub(base_rn, in_q.sample_weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      close_valid_q <= 1'b0;
      open_q        <= 1'b0;
      pend_q        <= 1'b0;
    end else begin
      if (sample.ready) begin
        in_valid_q <= sample.valid;
      end
      if (close_free) begin
        close_valid_q <= in_fire && in_q.last_in_column;
      end
      if (in_fire) begin
        open_q <= !in_q.last_in_column;
        pend_q <= !in_q.last_in_column;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample.ready && sample.valid) begin
      in_q.feature_value  <= sample.feature_value;
      in_q.label_positive <= sample.label_positive;
      in_q.sample_weight  <= sample.sample_weight;
      in_q.column_index   <= sample.column_index;
      in_q.last_in_column <= sample.last_in_column;
      in_q.last_column    <= sample.last_column;
    end
    if (in_fire) begin
      run_pos_q <= run_pos_d;
      run_neg_q <= run_neg_d;
      min_pos_q <= min_pos_d;
      min_neg_q <= min_neg_d;
      thr_pos_q <= thr_pos_d;
      thr_neg_q <= thr_neg_d;
      prev_q    <= in_q.feature_value;
    end
    if (in_fire && in_q.last_in_column && close_free) begin
      close_q.min_pos  <= min_pos_d;
      close_q.min_neg  <= min_neg_d;
      close_q.thr_pos  <= thr_pos_d;
      close_q.thr_neg  <= thr_neg_d;
      close_q.run_pos  <= run_pos_d;
      close_q.run_neg  <= run_neg_d;
      close_q.value    <= in_q.feature_value;
      close_q.col      <= in_q.column_index;
      close_q.last_col <= in_q.last_column;
    end
  end

  assign close_valid_o = close_valid_q;
  assign close_o       = close_q;

endmodule

>>> design/dsts_pick.sv
module dsts_pick (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             close_valid_i,
  input  dsts_pkg::close_t close_i,
  output logic             close_ready_o,
  output logic             stump_valid_o,
  output dsts_pkg::stump_t stump_o,
  input  logic             stump_ready_i
);
  import dsts_pkg::*;

  logic   stump_valid_q;
  stump_t stump_q, stump_d;

  assign close_ready_o = !stump_valid_q || stump_ready_i;

  // last candidate of the column, then the polarity choice
  always_comb begin
    err_t  mp, mn;
    feat_t tp, tn;
    mp = close_i.min_pos;
    tp = close_i.thr_pos;
    if (close_i.run_pos < close_i.min_pos) begin
      mp = close_i.run_pos;
      tp = close_i.value;
    end
    mn = close_i.min_neg;
    tn = close_i.thr_neg;
    if (close_i.run_neg < close_i.min_neg) begin
      mn = close_i.run_neg;
      tn = close_i.value;
    end
    // equal errors go to polarity 0
    if (mp < mn) begin
      stump_d.err = mp;
      stump_d.pol = 1'b1;
      stump_d.thr = tp;
    end else begin
      stump_d.err = mn;
      stump_d.pol = 1'b0;
      stump_d.thr = tn;
    end
    stump_d.col      = close_i.col;
    stump_d.last_col = close_i.last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stump_valid_q <= 1'b0;
    end else if (close_ready_o) begin
      stump_valid_q <= close_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_ready_o && close_valid_i) begin
      stump_q <= stump_d;
    end
  end

  assign stump_valid_o = stump_valid_q;
  assign stump_o       = stump_q;

endmodule

>>> design/dsts_rank.sv
module dsts_rank (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             stump_valid_i,
  input  dsts_pkg::stump_t stump_i,
  output logic             stump_ready_o,
  dsts_result_if.source    result
);
  import dsts_pkg::*;

  logic    out_valid_q;
  result_t out_q;
  err_t    best_err_q, nb_err;
  logic    best_pol_q, nb_pol;
  feat_t   best_thr_q, nb_thr;
  col_t    best_col_q, nb_col;
  logic    take;

  assign stump_ready_o = !out_valid_q || result.ready;
  assign take          = stump_ready_o && stump_valid_i;

  // ties keep the earlier column
  always_comb begin
    if (stump_i.err < best_err_q) begin
      nb_err = stump_i.err;
      nb_pol = stump_i.pol;
      nb_thr = stump_i.thr;
      nb_col = stump_i.col;
    end else begin
      nb_err = best_err_q;
      nb_pol = best_pol_q;
      nb_thr = best_thr_q;
      nb_col = best_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      best_err_q  <= ErrMax;
      best_pol_q  <= 1'b0;
      best_thr_q  <= '0;
      best_col_q  <= '0;
    end else begin
      if (stump_ready_o) begin
        out_valid_q <= stump_valid_i;
      end
      if (take) begin
        if (stump_i.last_col) begin
          best_err_q <= ErrMax;
          best_pol_q <= 1'b0;
          best_thr_q <= '0;
          best_col_q <= '0;
        end else begin
          best_err_q <= nb_err;
          best_pol_q <= nb_pol;
          best_thr_q <= nb_thr;
          best_col_q <= nb_col;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.col_error      <= stump_i.err;
      out_q.col_polarity   <= stump_i.pol;
      out_q.col_threshold  <= stump_i.thr;
      out_q.col_number     <= stump_i.col;
      out_q.best_error     <= nb_err;
      out_q.best_polarity  <= nb_pol;
      out_q.best_threshold <= nb_thr;
      out_q.best_column    <= nb_col;
      out_q.round_done     <= stump_i.last_col;
    end
  end

  assign result.valid          = out_valid_q;
  assign result.col_error      = out_q.col_error;
  assign result.col_polarity   = out_q.col_polarity;
  assign result.col_threshold  = out_q.col_threshold;
  assign result.col_number     = out_q.col_number;
  assign result.best_error     = out_q.best_error;
  assign result.best_polarity  = out_q.best_polarity;
  assign result.best_threshold = out_q.best_threshold;
  assign result.best_column    = out_q.best_column;
  assign result.round_done     = out_q.round_done;

endmodule

>>> design/decision_stump_threshold_search_core.sv
// throughput: one sample item per cycle while no closing sample waits on a full
// close register; a result item per closing sample
// rate is set by the running-error loop in dsts_scan: one saturating add, one
// saturating subtract and two compares against the column registers per cycle
// reset: asynchronous, active low; clears valids, column open flags, totals
// to zero and the round best to all-ones error
module decision_stump_threshold_search_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dsts_pkg::cfg_idx_e cfg_idx_i,
  input  dsts_pkg::err_t     cfg_data_i,
  dsts_sample_if.sink        sample_i,
  dsts_result_if.source      result_o
);
  import dsts_pkg::*;

  // scan -> pick: column state captured at the closing sample
  logic   close_valid, close_ready;
  close_t close_rec;

  // pick -> rank: chosen stump of the finished column
  logic   stump_valid, stump_ready;
  stump_t stump;

  // input register plus running errors; each sample checks the previous
  // value as a candidate, then adds or subtracts its weight
  dsts_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample        (sample_i),
    .close_valid_o (close_valid),
    .close_o       (close_rec),
    .close_ready_i (close_ready)
  );

  // final candidate at column end and polarity choice
  dsts_pick u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .close_valid_i (close_valid),
    .close_i       (close_rec),
    .close_ready_o (close_ready),
    .stump_valid_o (stump_valid),
    .stump_o       (stump),
    .stump_ready_i (stump_ready)
  );

  // round best tracking and output register; samples that close no column
  // keep flowing while a result item waits here
  dsts_rank u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stump_valid_i (stump_valid),
    .stump_i       (stump),
    .stump_ready_o (stump_ready),
    .result        (result_o)
  );

endmodule

>>> bench/dsts_stump_checker.sv
module dsts_stump_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dsts_pkg::cfg_idx_e cfg_idx_i,
  input  dsts_pkg::err_t     cfg_data_i,
  dsts_sample_if             smp_i,
  dsts_result_if             res_i,
  output int unsigned        fault_cnt_o,
  output int unsigned        pending_cnt_o,
  output int unsigned        checked_cnt_o
);
  import dsts_pkg::*;

  err_t    tot_pos, tot_neg;
  err_t    run_pos, run_neg;
  err_t    min_pos, min_neg;
  feat_t   thr_pos, thr_neg;
  feat_t   last_val;
  logic    cand_open, col_open;
  err_t    best_err;
  logic    best_pol;
  feat_t   best_thr;
  col_t    best_col;
  result_t stump_q [$];

  function automatic err_t err_plus(err_t a, weight_t w);
    logic [32:0] s;
    s = {1'b0, a} + 33'(w);
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic err_t err_minus(err_t a, weight_t w);
    if (a < err_t'(w)) return '0;
    return a - err_t'(w);
  endfunction

  task automatic score_candidate();
    if (run_pos < min_pos) begin
      min_pos = run_pos;
      thr_pos = last_val;
    end
    if (run_neg < min_neg) begin
      min_neg = run_neg;
      thr_neg = last_val;
    end
  endtask

  task automatic clear_best();
    best_err = '1;
    best_pol = 1'b0;
    best_thr = '0;
    best_col = '0;
  endtask

  // models every sample; queues a predicted stump for a closing item only
  task automatic absorb_sample();
    result_t r;
    err_t    cerr;
    logic    cpol;
    feat_t   cthr;
    if (!col_open) begin
      run_pos   = tot_pos;
      run_neg   = tot_neg;
      min_pos   = '1;
      min_neg   = '1;
      thr_pos   = '0;
      thr_neg   = '0;
      cand_open = 1'b0;
      col_open  = 1'b1;
    end
    if (cand_open && smp_i.feature_value != last_val) score_candidate();
    if (smp_i.label_positive) begin
      run_pos = err_minus(run_pos, smp_i.sample_weight);
      run_neg = err_plus(run_neg, smp_i.sample_weight);
    end else begin
      run_pos = err_plus(run_pos, smp_i.sample_weight);
      run_neg = err_minus(run_neg, smp_i.sample_weight);
    end
    last_val  = smp_i.feature_value;
    cand_open = 1'b1;
    if (!smp_i.last_in_column) return;

    score_candidate();
    if (min_pos < min_neg) begin
      cerr = min_pos;
      cpol = 1'b1;
      cthr = thr_pos;
    end else begin
      cerr = min_neg;
      cpol = 1'b0;
      cthr = thr_neg;
    end
    if (cerr < best_err) begin
      best_err = cerr;
      best_pol = cpol;
      best_thr = cthr;
      best_col = smp_i.column_index;
    end
    r.col_error      = cerr;
    r.col_polarity   = cpol;
    r.col_threshold  = cthr;
    r.col_number     = smp_i.column_index;
    r.best_error     = best_err;
    r.best_polarity  = best_pol;
    r.best_threshold = best_thr;
    r.best_column    = best_col;
    r.round_done     = smp_i.last_column;
    stump_q.push_back(r);
    col_open  = 1'b0;
    cand_open = 1'b0;
    if (smp_i.last_column) clear_best();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_cnt_o++;
      if (fault_cnt_o <= 10)
        $display("%0t: stump mismatch on %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (stump_q.size() == 0) begin
      fault_cnt_o++;
      if (fault_cnt_o <= 10)
        $display("%0t: result item with none expected: col %0d error %h", $time,
                 res_i.col_number, res_i.col_error);
      return;
    end
    want = stump_q.pop_front();
    check_field("col_error", want.col_error, res_i.col_error);
    check_field("col_polarity", 32'(want.col_polarity), 32'(res_i.col_polarity));
    check_field("col_threshold", want.col_threshold, res_i.col_threshold);
    check_field("col_number", 32'(want.col_number), 32'(res_i.col_number));
    check_field("best_error", want.best_error, res_i.best_error);
    check_field("best_polarity", 32'(want.best_polarity), 32'(res_i.best_polarity));
    check_field("best_threshold", want.best_threshold, res_i.best_threshold);
    check_field("best_column", 32'(want.best_column), 32'(res_i.best_column));
    check_field("round_done", 32'(want.round_done), 32'(res_i.round_done));
    checked_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_pos   = '0;
      tot_neg   = '0;
      run_pos   = '0;
      run_neg   = '0;
      min_pos   = '1;
      min_neg   = '1;
      thr_pos   = '0;
      thr_neg   = '0;
      last_val  = '0;
      cand_open = 1'b0;
      col_open  = 1'b0;
      clear_best();
      stump_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTotalPos: tot_pos = cfg_data_i;
          CfgTotalNeg: tot_neg = cfg_data_i;
          default: ;
        endcase
      end
      if (smp_i.valid && smp_i.ready) absorb_sample();
      if (res_i.valid && res_i.ready) check_result();
      pending_cnt_o <= stump_q.size();
    end
  end

endmodule

>>> bench/tb_decision_stump_threshold_search_core.sv
module tb_decision_stump_threshold_search_core;
  import dsts_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_e cfg_idx_i;
  err_t     cfg_data_i;

  dsts_sample_if sample_if ();
  dsts_result_if result_if ();

  // counters handed up by the checker
  int unsigned fault_cnt, pending_cnt, checked_cnt;

  // stimulus bookkeeping for the summary
  int unsigned items_sent, rounds_run, noisy_rounds;

  // random idling on both channels, switched off for one long stretch
  bit gaps_on = 1'b1;

  decision_stump_threshold_search_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  dsts_stump_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .smp_i         (sample_if),
    .res_i         (result_if),
    .fault_cnt_o   (fault_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side: stall with a probability of 16 percent while gaps are on
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !gaps_on || ($urandom_range(99) >= 16);
    end
  end

  // one sample item; valid stays high afterwards so back-to-back items
  // never see valid dropped and raised in the same step
  task automatic put(input feat_t value, input logic positive, input weight_t weight,
                     input col_t col, input logic closes, input logic ends_round);
    logic took;
    while (gaps_on && $urandom_range(99) < 16) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid          <= 1'b1;
    sample_if.feature_value  <= value;
    sample_if.label_positive <= positive;
    sample_if.sample_weight  <= weight;
    sample_if.column_index   <= col;
    sample_if.last_in_column <= closes;
    sample_if.last_column    <= ends_round;
    // ready only moves at clock edges, so its value at the falling edge is
    // the one the next rising edge sees
    do begin
      @(negedge clk_i);
      took = sample_if.ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
  endtask

  // drop valid and hold off until every expected stump is back, then leave
  // room for the pipeline to drain before anything else happens
  task automatic settle();
    sample_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // both class totals, back to back; only called with no column open
  task automatic write_totals(input err_t pos_total, input err_t neg_total);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTotalPos;
    cfg_data_i <= pos_total;
    @(posedge clk_i);
    cfg_idx_i  <= CfgTotalNeg;
    cfg_data_i <= neg_total;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // totals that do not match the samples, to reach the saturation paths
  function automatic err_t skew_total(err_t exact);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return err_t'($urandom);
      default: return exact + $urandom_range(0, 255);
    endcase
  endfunction

  // one boosting round: a fixed sample set (labels, weights) scanned as
  // several feature columns, each on its own random values; the totals are
  // the class weight sums and the columns sorted unless the round is noisy
  task automatic run_round(input int n_smp, input int n_col, input bit noisy);
    logic    lab  [16];
    weight_t wt   [16];
    int      perm [16];
    feat_t   vals [16];
    err_t    sum_pos, sum_neg;
    feat_t   base, hold;
    col_t    col;
    int      j, tmp, mode;
    bit      sorted, jitter, stray;
    sum_pos = '0;
    sum_neg = '0;
    for (int k = 0; k < n_smp; k++) begin
      lab[k] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: wt[k] = '0;
        1: wt[k] = '1;
        default: wt[k] = weight_t'($urandom);
      endcase
      if (lab[k]) sum_pos += err_t'(wt[k]);
      else sum_neg += err_t'(wt[k]);
      perm[k] = k;
    end
    if (noisy) write_totals(skew_total(sum_pos), skew_total(sum_neg));
    else write_totals(sum_pos, sum_neg);

    for (int c = 0; c < n_col; c++) begin
      // value spread: wide, clustered with ties, the two extremes, near zero
      mode = $urandom_range(0, 3);
      base = feat_t'($urandom);
      for (int k = 0; k < n_smp; k++) begin
        case (mode)
          0: vals[k] = feat_t'($urandom);
          1: vals[k] = base + feat_t'($urandom_range(0, 3));
          2: vals[k] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: vals[k] = feat_t'($urandom_range(0, 20)) - 10;
        endcase
      end
      // broken columns: unsorted values, index changes, stray round flags
      sorted = !(noisy && $urandom_range(0, 1));
      jitter = noisy && $urandom_range(0, 1);
      stray  = noisy && $urandom_range(0, 1);
      if (sorted) begin
        for (int k = 1; k < n_smp; k++) begin
          hold = vals[k];
          j = k - 1;
          while (j >= 0 && vals[j] > hold) begin
            vals[j + 1] = vals[j];
            j--;
          end
          vals[j + 1] = hold;
        end
      end
      // samples land on the sorted values in a fresh order per column
      for (int k = n_smp - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      col = col_t'($urandom);
      for (int k = 0; k < n_smp; k++) begin
        put(vals[k], lab[perm[k]], wt[perm[k]],
            (jitter && k != n_smp - 1) ? col_t'($urandom) : col,
            k == n_smp - 1,
            (k == n_smp - 1) ? (c == n_col - 1) : (stray && $urandom_range(0, 1)));
      end
    end
    settle();
    rounds_run++;
    if (noisy) noisy_rounds++;
  endtask

  initial begin
    bit noisy;
    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= CfgTotalPos;
    cfg_data_i               <= '0;
    sample_if.valid          <= 1'b0;
    sample_if.feature_value  <= '0;
    sample_if.label_positive <= 1'b0;
    sample_if.sample_weight  <= '0;
    sample_if.column_index   <= '0;
    sample_if.last_in_column <= 1'b0;
    sample_if.last_column    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // totals still zero from reset: lone sample at the most negative value,
    // full weight, top column index; the positive error clamps at zero
    put(32'sh8000_0000, 1'b1, '1, 10'h3FF, 1'b1, 1'b0);
    settle();

    // both totals all ones: adds clamp at the top; all values tie at the
    // largest value, round flag set early, index moves inside the column
    write_totals('1, '1);
    put(32'sh7FFF_FFFF, 1'b0, '1, 10'h155, 1'b0, 1'b1);
    put(32'sh7FFF_FFFF, 1'b1, '0, 10'h2AA, 1'b0, 1'b0);
    put(32'sh7FFF_FFFF, 1'b0, '1, 10'd7, 1'b1, 1'b1);
    settle();

    // nothing beats all ones: threshold stays zero, polarity tie picks
    // reversed, round best keeps its reset values
    put(32'sd5, 1'b0, '0, 10'd3, 1'b1, 1'b0);
    settle();

    // identical columns in one round: the earlier column keeps the best
    write_totals(32'd100, 32'd100);
    put(-32'sd3, 1'b1, 24'd60, 10'd12, 1'b0, 1'b0);
    put(32'sd2, 1'b0, 24'd100, 10'd12, 1'b0, 1'b0);
    put(32'sd9, 1'b1, 24'd40, 10'd12, 1'b1, 1'b0);
    put(-32'sd3, 1'b1, 24'd60, 10'd4, 1'b0, 1'b0);
    put(32'sd2, 1'b0, 24'd100, 10'd4, 1'b0, 1'b0);
    put(32'sd9, 1'b1, 24'd40, 10'd4, 1'b1, 1'b1);
    settle();

    // descending values with ties, zero positive total
    write_totals('0, 32'h0000_FFFF);
    put(32'sd50, 1'b0, '1, 10'd200, 1'b0, 1'b0);
    put(-32'sd50, 1'b1, 24'h80, 10'd200, 1'b0, 1'b0);
    put(-32'sd50, 1'b0, 24'd1, 10'd200, 1'b0, 1'b0);
    put(-32'sd1000, 1'b1, 24'h00FF_FF, 10'd200, 1'b1, 1'b1);
    settle();

    // random rounds, with a long quiet stretch in the middle
    while (items_sent < 1040) begin
      gaps_on = !(items_sent >= 300 && items_sent < 600);
      noisy = $urandom_range(0, 4) == 0;
      run_round(($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 10),
                $urandom_range(1, 5), noisy);
    end
    settle();

    $display("summary: %0d sample items in %0d rounds, %0d of them with skewed totals",
             items_sent, rounds_run, noisy_rounds);
    $display("summary: (or broken columns), %0d column results compared, %0d mismatches",
             checked_cnt, fault_cnt);
    if (fault_cnt == 0 && pending_cnt == 0) begin
      $display("tb_decision_stump_threshold_search_core: done, clean");
    end else begin
      $display("tb_decision_stump_threshold_search_core: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout: %0d results still expected", pending_cnt);
    $display("tb_decision_stump_threshold_search_core: done, errors");
    $finish;
  end

endmodule
